@@ sv/plfe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plfe_pkg
// shared types, constants and colour packing helpers of the palette fade engine
// ----------------------------------------------------------------------------
package plfe_pkg;

  localparam int Entries   = 24;
  localparam int EntryW    = $clog2(Entries);
  localparam int IndexW    = 5;
  localparam int ColourW   = 16;
  localparam int OutColW   = 15;
  localparam int LevelW    = 16;
  localparam int StepsW    = 15;
  localparam int StepShift = 7;

  localparam logic [StepsW-1:0] FadeStepsReset = 15'd128;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef struct packed {
    logic                 cmd;
    logic [IndexW-1:0]    entry_index;
    logic [ColourW-1:0]   current_colour;
    logic [ColourW-1:0]   target_colour;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0]  out_index;
    logic [OutColW-1:0] out_colour;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [LevelW-1:0] r;
    logic [LevelW-1:0] g;
    logic [LevelW-1:0] b;
  } rgb_t;

  // controller to datapath
  typedef struct packed {
    logic              load_en;
    logic              tick_en;
    logic [EntryW-1:0] entry;
    logic              last;
  } dp_cmd_t;

  // 5-bit channel goes to bits 14..10 of the level
  function automatic rgb_t unpack_colour(input logic [ColourW-1:0] c);
    rgb_t v;
    v.r = {1'b0, c[3:0],  c[12], 10'b0};
    v.g = {1'b0, c[7:4],  c[13], 10'b0};
    v.b = {1'b0, c[11:8], c[14], 10'b0};
    return v;
  endfunction

  function automatic logic [OutColW-1:0] repack_colour(input rgb_t v);
    return {v.b[10], v.g[10], v.r[10], v.b[14:11], v.g[14:11], v.r[14:11]};
  endfunction

  // (to - from) >>> 7, low 16 bits
  function automatic logic [LevelW-1:0] step_of(input logic [LevelW-1:0] from,
                                                input logic [LevelW-1:0] to);
    logic signed [LevelW:0] d;
    logic signed [LevelW:0] s;
    d = $signed({1'b0, to}) - $signed({1'b0, from});
    s = d >>> StepShift;
    return s[LevelW-1:0];
  endfunction

endpackage

@@ sv/palette_linear_fade_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_linear_fade_engine
// linear fade of a 24-entry palette toward target colours
// ----------------------------------------------------------------------------
// A load (cmd 0) stores the entry's levels and steps and
// re-arms the fade for fade_steps ticks; busy stays low. A tick (cmd 1) while
// armed sweeps the entry table one entry per cycle, with busy high all
// through, and 24 result beats follow on res_valid_o in the cycle after each
// entry, index order, last set on the final entry. A tick while not armed is
// taken and yields no beats. Beats cannot be held off, so the receiver must
// take every cycle that res_valid_o is high. The config channel is always
// ready; write it only while the block is idle.
module palette_linear_fade_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  plfe_pkg::in_item_t                item_i,
  output logic                              res_valid_o,
  output plfe_pkg::out_item_t               res_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [plfe_pkg::StepsW-1:0]       cfg_data_i
);

  plfe_pkg::dp_cmd_t dp_cmd;

  assign cfg_ready_o = 1'b1;

  plfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .cmd_i      (item_i.cmd),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .busy_o     (busy),
    .dp_cmd_o   (dp_cmd)
  );

  plfe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dp_cmd_i    (dp_cmd),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

@@ sv/plfe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plfe_ctrl
// command sequencer: fade arming, tick count and the per-entry sweep counter
// ----------------------------------------------------------------------------
module plfe_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          cmd_i,
  input  logic                          cfg_we_i,
  input  logic [plfe_pkg::StepsW-1:0]   cfg_data_i,
  output logic                          busy_o,
  output plfe_pkg::dp_cmd_t             dp_cmd_o
);

  localparam logic StIdle  = 1'b0;
  localparam logic StSweep = 1'b1;

  logic                          state_q, state_d;
  logic [plfe_pkg::EntryW-1:0]   cnt_q, cnt_d;
  logic [plfe_pkg::StepsW-1:0]   ticks_q, ticks_d;
  logic                          fading_q, fading_d;
  logic [plfe_pkg::StepsW-1:0]   fade_steps_q;
  logic                          accept;
  logic                          last_entry;
  logic [plfe_pkg::StepsW-1:0]   ticks_dec;

  assign accept     = start_i && (state_q == StIdle);
  assign last_entry = (cnt_q == plfe_pkg::EntryW'(plfe_pkg::Entries - 1));
  assign ticks_dec  = ticks_q - plfe_pkg::StepsW'(1);
  assign busy_o     = (state_q == StSweep);

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    ticks_d  = ticks_q;
    fading_d = fading_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (cmd_i == plfe_pkg::CmdLoad) begin
            ticks_d  = fade_steps_q;
            fading_d = 1'b1;
          end else if (fading_q) begin
            state_d = StSweep;
            cnt_d   = '0;
          end
        end
      end
      StSweep: begin
        cnt_d = cnt_q + plfe_pkg::EntryW'(1);
        if (last_entry) begin
          state_d = StIdle;
          cnt_d   = '0;
          ticks_d = ticks_dec;
          if (ticks_dec == '0) begin
            fading_d = 1'b0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    dp_cmd_o.load_en = accept && (cmd_i == plfe_pkg::CmdLoad);
    dp_cmd_o.tick_en = (state_q == StSweep);
    dp_cmd_o.entry   = cnt_q;
    dp_cmd_o.last    = last_entry;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      ticks_q      <= '0;
      fading_q     <= 1'b0;
      fade_steps_q <= plfe_pkg::FadeStepsReset;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      ticks_q  <= ticks_d;
      fading_q <= fading_d;
      if (cfg_we_i) begin
        fade_steps_q <= cfg_data_i;
      end
    end
  end

endmodule

@@ sv/plfe_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plfe_dp
// level and step tables, one entry updated per cycle, registered result beat
// ----------------------------------------------------------------------------
module plfe_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  plfe_pkg::dp_cmd_t    dp_cmd_i,
  input  plfe_pkg::in_item_t   item_i,
  output logic                 res_valid_o,
  output plfe_pkg::out_item_t  res_o
);

  plfe_pkg::rgb_t level_q [plfe_pkg::Entries];
  plfe_pkg::rgb_t step_q  [plfe_pkg::Entries];

  plfe_pkg::rgb_t cur_lvl, tgt_lvl, new_step;
  plfe_pkg::rgb_t rd_lvl, rd_step, sum_lvl;
  logic           load_hit;
  logic [plfe_pkg::EntryW-1:0] load_idx;

  logic                 res_valid_q;
  plfe_pkg::out_item_t  res_q;

  always_comb begin
    cur_lvl    = plfe_pkg::unpack_colour(item_i.current_colour);
    tgt_lvl    = plfe_pkg::unpack_colour(item_i.target_colour);
    new_step.r = plfe_pkg::step_of(cur_lvl.r, tgt_lvl.r);
    new_step.g = plfe_pkg::step_of(cur_lvl.g, tgt_lvl.g);
    new_step.b = plfe_pkg::step_of(cur_lvl.b, tgt_lvl.b);
    // out of range loads still arm, but write nothing
    load_hit   = dp_cmd_i.load_en && (32'(item_i.entry_index) < plfe_pkg::Entries);
    load_idx   = plfe_pkg::EntryW'(item_i.entry_index);
  end

  always_comb begin
    rd_lvl    = level_q[dp_cmd_i.entry];
    rd_step   = step_q[dp_cmd_i.entry];
    sum_lvl.r = rd_lvl.r + rd_step.r;
    sum_lvl.g = rd_lvl.g + rd_step.g;
    sum_lvl.b = rd_lvl.b + rd_step.b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < plfe_pkg::Entries; i++) begin
        level_q[i] <= '0;
        step_q[i]  <= '0;
      end
    end else begin
      if (load_hit) begin
        level_q[load_idx] <= cur_lvl;
        step_q[load_idx]  <= new_step;
      end else if (dp_cmd_i.tick_en) begin
        level_q[dp_cmd_i.entry] <= sum_lvl;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= dp_cmd_i.tick_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.tick_en) begin
      res_q.out_index  <= plfe_pkg::IndexW'(dp_cmd_i.entry);
      res_q.out_colour <= plfe_pkg::repack_colour(sum_lvl);
      res_q.last       <= dp_cmd_i.last;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ sv/plfe_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plfe_checker
// port-level checks of the result beat sequence
// ----------------------------------------------------------------------------
module plfe_checker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 busy,
  input  logic                 res_valid_o,
  input  plfe_pkg::out_item_t  res_o
);

  // a run of beats is contiguous
  a_run_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=> res_valid_o)
    else $error("result run broken before last beat");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |=>
      res_o.out_index == plfe_pkg::IndexW'($past(res_o.out_index) + 1'b1))
    else $error("result index did not advance by one");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |-> !busy)
    else $error("last beat shown while still sweeping");

  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o)
    else $error("beat directly after last beat");

endmodule

bind palette_linear_fade_engine plfe_checker u_plfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
